### design/min_cost_route_table_core_defines.svh
// assertion macros for the route table checker
`ifndef MIN_COST_ROUTE_TABLE_CORE_DEFINES_SVH
`define MIN_COST_ROUTE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define MCRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define MCRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mcrt_pkg.sv
// shared types and constants of the min cost route table
package mcrt_pkg;

    // default number of table rows
    localparam int MCRT_ENTRIES = 64;

    localparam int NODE_W  = 16;
    localparam int STACK_W = 64;
    localparam int COST_W  = 16;
    localparam int HOP_W   = 8;
    localparam int ROUND_W = 16;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    // request transaction
    typedef struct packed {
        t_op                opcode;
        logic [NODE_W-1:0]  dest_node;
        logic [STACK_W-1:0] stack_key;
        logic [COST_W-1:0]  route_cost;
        logic [NODE_W-1:0]  next_node;
        logic [NODE_W-1:0]  adapter_id;
        logic [HOP_W-1:0]   hop_count;
        logic [HOP_W-1:0]   hop_limit;
        logic [ROUND_W-1:0] round_number;
    } t_req;

    // response transaction
    typedef struct packed {
        logic               hit;
        logic               accepted;
        logic               table_full;
        logic [COST_W-1:0]  found_cost;
        logic [NODE_W-1:0]  found_next_node;
        logic [NODE_W-1:0]  found_adapter;
        logic [HOP_W-1:0]   found_hops;
        logic [HOP_W-1:0]   found_hop_limit;
        logic [ROUND_W-1:0] found_round;
    } t_rsp;

    // route data held per row in the data memory
    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [NODE_W-1:0]  next_node;
        logic [NODE_W-1:0]  adapter;
        logic [HOP_W-1:0]   hops;
        logic [HOP_W-1:0]   hop_limit;
        logic [ROUND_W-1:0] round;
    } t_row;

    // key search status from the match array
    typedef struct packed {
        logic hit;
        logic has_free;
        logic cheaper;
    } t_cam_flags;

endpackage

### design/mcrt_if.sv
// valid/ready channels for route table requests and responses
interface mcrt_req_if
    import mcrt_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcrt_rsp_if
    import mcrt_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/mcrt_cam.sv
// key match array: valid bits, keys and costs of all rows, compared in parallel
module mcrt_cam
    import mcrt_pkg::*;
#(
    parameter int ENTRIES = MCRT_ENTRIES,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NODE_W-1:0]  i_dest,
    input  logic [STACK_W-1:0] i_stack,
    input  logic [COST_W-1:0]  i_cost,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_idx,
    output t_cam_flags         o_flags,
    output logic [IDX_W-1:0]   o_match_idx,
    output logic [IDX_W-1:0]   o_free_idx
);

    logic [ENTRIES-1:0] r_valid;
    logic [NODE_W-1:0]  r_dest  [ENTRIES];
    logic [STACK_W-1:0] r_stack [ENTRIES];
    logic [COST_W-1:0]  r_cost  [ENTRIES];

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] cheap_vec;

    // per-row key compare and cost compare
    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            match_vec[e] = r_valid[e] && (r_dest[e] == i_dest) && (r_stack[e] == i_stack);
            cheap_vec[e] = i_cost < r_cost[e];
        end
    end

    // encode the matching row, keys are unique so at most one bit is set
    always_comb begin
        o_match_idx = '0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (match_vec[e]) begin
                o_match_idx = o_match_idx | IDX_W'(e);
            end
        end
    end

    // lowest free row
    always_comb begin
        o_free_idx = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (!r_valid[e]) begin
                o_free_idx = IDX_W'(e);
            end
        end
    end

    assign o_flags.hit      = |match_vec;
    assign o_flags.has_free = ~&r_valid;
    assign o_flags.cheaper  = |(match_vec & cheap_vec);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    // keys and costs
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_dest[i_wr_idx]  <= i_dest;
            r_stack[i_wr_idx] <= i_stack;
            r_cost[i_wr_idx]  <= i_cost;
        end
    end

endmodule

### design/min_cost_route_table_core.sv
// min cost route table: top level with request stage, data memory and response register
//
// Keeps the cheapest route per (destination node, protocol stack key) in ENTRIES rows.
// A lookup returns the stored row or hit=0 with zero fields; an insert fills the lowest
// free row for a new key, or overwrites the row of a known key only when the offered cost
// is strictly lower; a new key with no free row is dropped and flags table_full.
// One transaction is taken every clock cycle while o_rsp does not stall; a request is
// registered in the request stage, its result in the response register. The rate is set
// by the combinational match array search; it updates at the edge taking the next request.
// Reset clears all valid bits at once, so no clearing pass follows reset.
module min_cost_route_table_core
    import mcrt_pkg::*;
#(
    parameter int ENTRIES = MCRT_ENTRIES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcrt_req_if.sink   i_req,
    mcrt_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic             r_a_valid;
    t_req             r_a_req;
    logic             r_b_valid;
    logic             r_b_hit;
    logic             r_b_accepted;
    logic             r_b_full;
    logic             r_b_show;
    t_row             r_rd;
    t_row             r_mem [ENTRIES];

    logic             advance;
    logic             a_fire;
    logic             is_ins;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    t_cam_flags       flags;
    t_row             wr_row;

    // pipeline flow control
    assign advance     = !r_b_valid || o_rsp.ready;
    assign i_req.ready = !r_a_valid || advance;
    assign a_fire      = r_a_valid && advance;

    // request stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_a_req <= i_req.data;
        end
    end

    // key search
    mcrt_cam #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dest      (r_a_req.dest_node),
        .i_stack     (r_a_req.stack_key),
        .i_cost      (r_a_req.route_cost),
        .i_wr_en     (wr_en),
        .i_wr_idx    (wr_idx),
        .o_flags     (flags),
        .o_match_idx (match_idx),
        .o_free_idx  (free_idx)
    );

    // insert decision: improve a known key or fill a free row
    assign is_ins = (r_a_req.opcode == OP_INSERT);
    assign wr_en  = a_fire && is_ins && (flags.hit ? flags.cheaper : flags.has_free);
    assign wr_idx = flags.hit ? match_idx : free_idx;

    assign wr_row.cost      = r_a_req.route_cost;
    assign wr_row.next_node = r_a_req.next_node;
    assign wr_row.adapter   = r_a_req.adapter_id;
    assign wr_row.hops      = r_a_req.hop_count;
    assign wr_row.hop_limit = r_a_req.hop_limit;
    assign wr_row.round     = r_a_req.round_number;

    // route data memory, a lookup reads and an insert writes, never both at once
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_row;
        end
        if (a_fire && !is_ins) begin
            r_rd <= r_mem[match_idx];
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_hit      <= flags.hit;
            r_b_accepted <= wr_en;
            r_b_full     <= is_ins && !flags.hit && !flags.has_free;
            r_b_show     <= !is_ins && flags.hit;
        end
    end

    // response fields, zero unless a lookup hit
    assign o_rsp.valid                = r_b_valid;
    assign o_rsp.data.hit             = r_b_hit;
    assign o_rsp.data.accepted        = r_b_accepted;
    assign o_rsp.data.table_full      = r_b_full;
    assign o_rsp.data.found_cost      = r_b_show ? r_rd.cost      : '0;
    assign o_rsp.data.found_next_node = r_b_show ? r_rd.next_node : '0;
    assign o_rsp.data.found_adapter   = r_b_show ? r_rd.adapter   : '0;
    assign o_rsp.data.found_hops      = r_b_show ? r_rd.hops      : '0;
    assign o_rsp.data.found_hop_limit = r_b_show ? r_rd.hop_limit : '0;
    assign o_rsp.data.found_round     = r_b_show ? r_rd.round     : '0;

endmodule

### design/mcrt_checker.sv
// port-level checks on the route table responses, bound to the top level
`include "min_cost_route_table_core_defines.svh"

module mcrt_checker
    import mcrt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    logic any_found;

    assign any_found = (i_rsp.found_cost != '0) || (i_rsp.found_next_node != '0) ||
                       (i_rsp.found_adapter != '0) || (i_rsp.found_hops != '0) ||
                       (i_rsp.found_hop_limit != '0) || (i_rsp.found_round != '0);

    // a stalled response stays put
    `MCRT_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp), "response changed while stalled")

    // an insert is never both taken and dropped for lack of room
    `MCRT_ASSERT_IMP(a_acc_full, i_rsp_valid, !(i_rsp.accepted && i_rsp.table_full), "accepted and table_full together")

    // a full table only drops keys that were absent
    `MCRT_ASSERT_IMP(a_full_miss, i_rsp_valid && i_rsp.table_full, !i_rsp.hit, "table_full on a known key")

    // stored fields only come back on a lookup hit
    `MCRT_ASSERT_IMP(a_found_hit, i_rsp_valid && any_found, i_rsp.hit && !i_rsp.accepted && !i_rsp.table_full, "found fields without a lookup hit")

endmodule

bind min_cost_route_table_core mcrt_checker u_mcrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
